// ----- hdl/olpe_pkg.sv -----
// Shared types and constants for the one-wire LED pulse encoder.
// No dependencies; every other file of the block refers to it by scoped names.
package olpe_pkg;

   // Bits in one colour word as sent on the line (range 8 to 32).
   localparam int unsigned WORD_BITS  = 24;
   // Width of the colour word field on the request channel.
   localparam int unsigned COLOR_W    = 24;
   // Phase length registers and the tick counter.
   localparam int unsigned LEN_W      = 10;
   // Bit counter, wide enough to hold WORD_BITS itself.
   localparam int unsigned BITCNT_W   = $clog2(WORD_BITS + 1);
   // Register index on the configuration channel.
   localparam int unsigned CSR_IDX_W  = 1;

   localparam logic [LEN_W-1:0] LONG_RESET  = LEN_W'(36);
   localparam logic [LEN_W-1:0] SHORT_RESET = LEN_W'(16);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_CYCLES  = 1'b0,
      CSR_SHORT_CYCLES = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   // Phase lengths as seen by the encoder core.
   typedef struct packed {
      logic [LEN_W-1:0] long_cycles;
      logic [LEN_W-1:0] short_cycles;
   } timing_type;

   // One result item.
   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic load_accepted;
      logic word_done;
   } result_type;

   // A zero length counts as a single tick.
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      clamp_len = (len == '0) ? LEN_W'(1) : len;
   endfunction

endpackage

// ----- hdl/olpe_csr.sv -----
// Configuration registers of the one-wire LED pulse encoder: the two phase lengths.
// Depends on olpe_pkg.
module olpe_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [olpe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [olpe_pkg::LEN_W-1:0]           csr_wdata,
   output olpe_pkg::timing_type                 timing
);

   olpe_pkg::timing_type timing_ff;
   olpe_pkg::timing_type timing_in;

   always_comb begin
      timing_in = timing_ff;
      if (csr_valid) begin
         unique case (olpe_pkg::csr_index_type'(csr_index))
            olpe_pkg::CSR_LONG_CYCLES:  timing_in.long_cycles  = csr_wdata;
            olpe_pkg::CSR_SHORT_CYCLES: timing_in.short_cycles = csr_wdata;
            default:                    timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.long_cycles  <= olpe_pkg::LONG_RESET;
         timing_ff.short_cycles <= olpe_pkg::SHORT_RESET;
      end else begin
         timing_ff <= timing_in;
      end
   end

   assign timing = timing_ff;

endmodule

// ----- hdl/olpe_core.sv -----
// Waveform state and per-item next-state logic of the one-wire LED pulse encoder.
// Depends on olpe_pkg.
module olpe_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 op,
   input  logic [olpe_pkg::COLOR_W-1:0]         color_word,
   input  olpe_pkg::timing_type                 timing,
   output olpe_pkg::result_type                 result
);

   logic [olpe_pkg::WORD_BITS-1:0] shift_word_ff, shift_word_in;
   logic [olpe_pkg::BITCNT_W-1:0]  bits_left_ff,  bits_left_in;
   logic                           phase_high_ff, phase_high_in;
   logic [olpe_pkg::LEN_W-1:0]     phase_count_ff, phase_count_in;
   logic                           sending_ff,    sending_in;

   logic [olpe_pkg::LEN_W-1:0]     len_long;
   logic [olpe_pkg::LEN_W-1:0]     len_short;
   logic [olpe_pkg::LEN_W-1:0]     len;
   logic [olpe_pkg::LEN_W-1:0]     count_next;
   logic                           phase_end;
   logic [olpe_pkg::BITCNT_W-1:0]  bits_dec;

   assign len_long   = olpe_pkg::clamp_len(timing.long_cycles);
   assign len_short  = olpe_pkg::clamp_len(timing.short_cycles);
   // A one bit is long then short, a zero bit short then long.
   assign len        = (shift_word_ff[0] == phase_high_ff) ? len_long : len_short;
   assign count_next = phase_count_ff + olpe_pkg::LEN_W'(1);
   assign phase_end  = (count_next == '0) || (count_next >= len);
   assign bits_dec   = (bits_left_ff != '0) ? bits_left_ff - olpe_pkg::BITCNT_W'(1) : '0;

   always_comb begin
      shift_word_in  = shift_word_ff;
      bits_left_in   = bits_left_ff;
      phase_high_in  = phase_high_ff;
      phase_count_in = phase_count_ff;
      sending_in     = sending_ff;
      result         = '0;

      if (op == olpe_pkg::OP_LOAD) begin
         if (!sending_ff) begin
            shift_word_in        = olpe_pkg::WORD_BITS'(color_word);
            bits_left_in         = olpe_pkg::BITCNT_W'(olpe_pkg::WORD_BITS);
            phase_high_in        = 1'b1;
            phase_count_in       = '0;
            sending_in           = 1'b1;
            result.load_accepted = 1'b1;
         end
      end else if (sending_ff) begin
         result.pin_level = phase_high_ff;
         phase_count_in   = count_next;
         if (phase_end) begin
            phase_count_in = '0;
            if (phase_high_ff) begin
               phase_high_in = 1'b0;
            end else begin
               shift_word_in = shift_word_ff >> 1;
               bits_left_in  = bits_dec;
               if (bits_dec == '0) begin
                  sending_in       = 1'b0;
                  result.word_done = 1'b1;
               end else begin
                  phase_high_in = 1'b1;
               end
            end
         end
      end
      result.busy_res = sending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_word_ff  <= '0;
         bits_left_ff   <= '0;
         phase_high_ff  <= 1'b0;
         phase_count_ff <= '0;
         sending_ff     <= 1'b0;
      end else if (advance) begin
         shift_word_ff  <= shift_word_in;
         bits_left_ff   <= bits_left_in;
         phase_high_ff  <= phase_high_in;
         phase_count_ff <= phase_count_in;
         sending_ff     <= sending_in;
      end
   end

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      advance && result.load_accepted |=> sending_ff && phase_high_ff && bits_left_ff != '0)
      else $error("accepted load did not start a word");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      advance && result.word_done |=> !sending_ff)
      else $error("word end did not return the line to idle");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> bits_left_ff == '0)
      else $error("idle with bits still pending");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> bits_left_ff != '0)
      else $error("sending with no bits left");

   a_pin_high: assert property (@(posedge clock) disable iff (reset)
      result.pin_level |-> sending_ff && phase_high_ff && op == olpe_pkg::OP_TICK)
      else $error("line driven high outside a high phase");

endmodule

// ----- hdl/one_wire_led_pulse_encoder.sv -----
// Top level of the one-wire LED pulse encoder: input register, core and result register.
// Depends on olpe_pkg, olpe_csr and olpe_core.
//
// Usage. Each request item is either a tick (req_op = 0), standing for one time
// step of the LED line, or a load (req_op = 1) carrying a colour word in
// req_color_word. A load taken while idle starts a word, sent least significant
// bit first; a load while a word is in flight is refused (rsp_load_accepted = 0).
// Every request item yields exactly one response item giving the line level for
// that tick, whether a word is still in flight, whether a load was taken and
// whether this tick ended the word.
// An item is captured in the input register, worked on in one pass of short logic
// against the waveform state, and its result is held in the response register.
// Throughput is one item per cycle while rsp_stall is low, set by the single state
// update per item. While a finished result waits to be collected, the input
// register can still take one more item.
// When rsp_stall holds a result, the input register fills and then req_stall
// rises until the result is taken; nothing is lost or repeated.
// Reset (synchronous, active high) empties both registers, idles the line and
// loads the phase lengths 36 (long) and 16 (short). The configuration channel is
// always ready; it is to be written only while the block holds no item.
module one_wire_led_pulse_encoder (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [olpe_pkg::COLOR_W-1:0]         req_color_word,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_pin_level,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_load_accepted,
   output logic                                 rsp_word_done,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [olpe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [olpe_pkg::LEN_W-1:0]           csr_wdata
);

   olpe_pkg::timing_type timing;
   olpe_pkg::result_type core_result;

   logic                           in_valid_ff, in_valid_in;
   logic                           in_op_ff;
   logic [olpe_pkg::COLOR_W-1:0]   in_word_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   olpe_pkg::result_type           rsp_data_ff;

   logic move;      // input item goes through the core into the result register
   logic req_take;  // request item captured this cycle

   // The result register can take a new item when empty or being emptied.
   assign move      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   // The input register can load when empty or when its item moves on.
   assign req_stall = in_valid_ff && !move;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && rsp_stall);

   olpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timing    (timing)
   );

   olpe_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (move),
      .op         (in_op_ff),
      .color_word (in_word_ff),
      .timing     (timing),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // Payload registers follow their handshakes and need no reset.
      if (req_take) begin
         in_op_ff   <= req_op;
         in_word_ff <= req_color_word;
      end
      if (move) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pin_level     = rsp_data_ff.pin_level;
   assign rsp_busy_res      = rsp_data_ff.busy_res;
   assign rsp_load_accepted = rsp_data_ff.load_accepted;
   assign rsp_word_done     = rsp_data_ff.word_done;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !move)
      else $error("held result overwritten");

   a_held_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !move |=> in_valid_ff && $stable(in_op_ff) && $stable(in_word_ff))
      else $error("waiting input item lost or changed");

   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid_ff)
      else $error("item moved but no result presented");

endmodule
